// File: rtl/compacting_value_list_macros.svh
// assertion macros used by the compacting value list rtl
`ifndef COMPACTING_VALUE_LIST_MACROS_SVH
`define COMPACTING_VALUE_LIST_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CVL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define CVL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cvl_pkg.sv
// shared types and constants of the compacting value list
`default_nettype none

package cvl_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 6;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_DUMP   = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic compare;
      logic live;
      logic load;
      logic shift;
      logic wrap;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/cvl_req_if.sv
// request channel of the compacting value list
`default_nettype none

interface cvl_req_if import cvl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   op_type                   op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/cvl_rsp_if.sv
// result channel of the compacting value list
`default_nettype none

interface cvl_rsp_if import cvl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [INDEX_W-1:0]       index;
   logic signed [DATA_W-1:0] entry;
   logic                     last;

   modport source (output valid, output status, output index, output entry, output last,
                   input ready);
   modport sink   (input valid, input status, input index, input entry, input last,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/cvl_cell.sv
// one list slot: holds an entry, compares it, passes it to its lower neighbor
`default_nettype none

module cvl_cell import cvl_pkg::*; (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] key,
   input  logic signed [DATA_W-1:0] next_data,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data,
   output logic                     hit
);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = key;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.wrap) begin
         data_in = head_data;
      end
      hit_in = hit_ff;
      if (ctl.compare) begin
         hit_in = ctl.live && (data_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

`default_nettype wire

// File: rtl/compacting_value_list.sv
// compacting value list: append, search and delete are accepted, then run once the
// output is free (accept compares all cells, execute resolves first hit, delete shifts)
// dump sends one entry per cycle while the output is free, rotating the cell chain
// a waiting result holds only its output register; a new request is taken meanwhile
// synchronous active-high reset empties the list (count to zero), slot data is
// left as is and is only read below count
`default_nettype none
`include "compacting_value_list_macros.svh"

module compacting_value_list import cvl_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   cvl_req_if.sink     req_ch,
   cvl_rsp_if.source   rsp_ch
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   // sequencer state
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         dump_idx_ff, dump_idx_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic signed [DATA_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic                     rsp_last_ff, rsp_last_in;

   // cell chain wiring
   cell_ctl_type             ctl       [DEPTH];
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic signed [DATA_W-1:0] next_data [DEPTH];
   logic [DEPTH-1:0]         hit_vec;
   logic [DEPTH-1:0]         live;
   logic [DEPTH-1:0]         first_hit;
   logic [DEPTH-1:0]         at_or_after;
   logic [IDX_W-1:0]         hit_idx;
   logic signed [DATA_W-1:0] key;

   logic req_fire;
   logic out_free;
   logic exec_go;
   logic dump_go;
   logic found;
   logic dump_last;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign exec_go  = (state_ff == S_EXEC) && out_free;
   assign dump_go  = (state_ff == S_DUMP) && out_free;

   // compare key comes straight from the request, load key from the held request
   assign key = (state_ff == S_IDLE) ? req_ch.value : value_ff;

   // lowest hit as one-hot, and the mask of slots at or above it
   assign first_hit   = hit_vec & (~hit_vec + DEPTH'(1));
   assign at_or_after = ~(first_hit - DEPTH'(1));
   assign found       = |hit_vec;

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign dump_last = (CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff;

   // row of cells, each hands its entry down to the slot below
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign live[i] = count_ff > CNT_W'(i);

      if (i == DEPTH - 1) begin : g_tail
         assign next_data[i] = cell_data[i];
      end else begin : g_link
         assign next_data[i] = cell_data[i+1];
      end

      always_comb begin
         ctl[i].compare = req_fire;
         ctl[i].live    = live[i];
         // append writes the first free slot
         ctl[i].load    = exec_go && (op_ff == OP_APPEND) && (count_ff == CNT_W'(i));
         // delete closes the gap; dump rotates the live part of the list
         ctl[i].shift   = (exec_go && (op_ff == OP_DELETE) && at_or_after[i]) ||
                          (dump_go && live[i] && (count_ff != CNT_W'(i + 1)));
         // the head entry wraps to the top live slot during dump
         ctl[i].wrap    = dump_go && (count_ff == CNT_W'(i + 1));
      end

      cvl_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .key       (key),
         .next_data (next_data[i]),
         .head_data (cell_data[0]),
         .data      (cell_data[i]),
         .hit       (hit_vec[i])
      );
   end

   // sequencer and output register next values
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.op;
               value_in = req_ch.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               // single-result ops report here
               rsp_index_in = '0;
               rsp_entry_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               unique case (op_ff)
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_OK;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_SEARCH: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_status_in = ST_OK;
                        rsp_index_in  = INDEX_W'(hit_idx);
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_status_in = ST_OK;
                        rsp_index_in  = INDEX_W'(hit_idx);
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        dump_idx_in = '0;
                        state_in    = S_DUMP;
                     end
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               // head cell is the next entry in order; chain rotates under it
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = INDEX_W'(dump_idx_ff);
               rsp_entry_in  = cell_data[0];
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_idx_ff + IDX_W'(1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      dump_idx_ff   <= dump_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ports
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.index  = rsp_index_ff;
   assign rsp_ch.entry  = rsp_entry_ff;
   assign rsp_ch.last   = rsp_last_ff;

   // checks
   `CVL_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(DEPTH),
      "entry count beyond list depth")
   `CVL_ASSERT_IMP(a_dump_in_range, state_ff == S_DUMP, CNT_W'(dump_idx_ff) < count_ff,
      "dump index past last entry")
   `CVL_ASSERT_IMP(a_first_hit_onehot, state_ff == S_EXEC, $onehot0(first_hit),
      "first hit not one-hot")
   `CVL_ASSERT_NEXT(a_accept_to_exec, req_fire, state_ff == S_EXEC,
      "accepted request did not reach execute")

endmodule

`default_nettype wire
